// ===== design/pdfan_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PD fan level regulator: field widths, register indexes,
// datapath operation and jump codes, and the microcode program table.
// It depends on nothing else; the core imports it.
package pdfan_pkg;

    // Field and datapath widths.
    localparam int TempW  = 16;            // Q12.4 temperature
    localparam int GainW  = 16;            // Q8.8 gain
    localparam int LevelW = 8;             // fan level
    localparam int DiffW  = TempW + 1;     // temperature difference
    localparam int MulAW  = 34;            // multiplier operand A
    localparam int MulBW  = DiffW;         // multiplier operand B
    localparam int MulPW  = MulAW + MulBW; // full product
    localparam int ProdW  = GainW + DiffW; // gain times difference
    localparam int AccW   = 49;            // numerator, exact
    localparam int FracW  = 12;            // fraction bits of the numerator
    localparam int QuoW   = AccW - FracW;  // dividend and quotient
    localparam int CntW   = 6;             // divider iteration counter
    localparam int PcW    = 4;             // microcode step counter
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgNominal  = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgGainP    = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgGainD    = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgPeriod   = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgRegEvery = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgMaxLevel = 3'd5;

    // Datapath operation of one step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_P,
        OP_MUL_D,
        OP_MUL_S,
        OP_ADD_D,
        OP_ABS,
        OP_BIAS,
        OP_DIV,
        OP_APPLY,
        OP_PRIME,
        OP_COUNT,
        OP_EMIT
    } t_op;

    // How the step counter moves on.
    typedef enum logic [2:0] {
        J_NEXT,      // to the following step
        J_ALWAYS,    // to the target step
        J_FETCH,     // hold until an item is taken, then dispatch on state
        J_LOOP,      // repeat while the iteration counter is not zero
        J_WAIT_OUT   // hold until the output register is free, then target
    } t_jmp;

    typedef struct packed {
        t_op            op;
        t_jmp           jmp;
        logic [PcW-1:0] target;
    } t_ctrl;

    // Program addresses.
    localparam logic [PcW-1:0] AFetch = 4'd0;
    localparam logic [PcW-1:0] AMulP  = 4'd1;
    localparam logic [PcW-1:0] AMulD  = 4'd2;
    localparam logic [PcW-1:0] AMulS  = 4'd3;
    localparam logic [PcW-1:0] AAddD  = 4'd4;
    localparam logic [PcW-1:0] AAbs   = 4'd5;
    localparam logic [PcW-1:0] ABias  = 4'd6;
    localparam logic [PcW-1:0] ADiv   = 4'd7;
    localparam logic [PcW-1:0] AApply = 4'd8;
    localparam logic [PcW-1:0] APrime = 4'd9;
    localparam logic [PcW-1:0] ACount = 4'd10;
    localparam logic [PcW-1:0] AEmit  = 4'd11;

    // The microcode program, one control word per step.
    function automatic t_ctrl f_ucode(logic [PcW-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NONE, jmp: J_ALWAYS, target: AFetch};
        unique case (pc)
            AFetch:  w = '{op: OP_LOAD,  jmp: J_FETCH,    target: AMulP};
            AMulP:   w = '{op: OP_MUL_P, jmp: J_NEXT,     target: AFetch};
            AMulD:   w = '{op: OP_MUL_D, jmp: J_NEXT,     target: AFetch};
            AMulS:   w = '{op: OP_MUL_S, jmp: J_NEXT,     target: AFetch};
            AAddD:   w = '{op: OP_ADD_D, jmp: J_NEXT,     target: AFetch};
            AAbs:    w = '{op: OP_ABS,   jmp: J_NEXT,     target: AFetch};
            ABias:   w = '{op: OP_BIAS,  jmp: J_NEXT,     target: AFetch};
            ADiv:    w = '{op: OP_DIV,   jmp: J_LOOP,     target: AFetch};
            AApply:  w = '{op: OP_APPLY, jmp: J_ALWAYS,   target: AEmit};
            APrime:  w = '{op: OP_PRIME, jmp: J_ALWAYS,   target: AEmit};
            ACount:  w = '{op: OP_COUNT, jmp: J_NEXT,     target: AFetch};
            AEmit:   w = '{op: OP_EMIT,  jmp: J_WAIT_OUT, target: AFetch};
            default: w = '{op: OP_NONE,  jmp: J_ALWAYS,   target: AFetch};
        endcase
        return w;
    endfunction

endpackage

// ===== design/pd_fan_level_regulator_core.sv =====
`timescale 1ns / 1ps
// PD fan level regulator core: a microcoded sequencer over one multiplier,
// several adders and a one-bit-a-cycle restoring divider. Uses pdfan_pkg.
// A regulating item runs through fetch, 6 multiply and add steps, 37 divider
// iterations, apply and emit, the divider loop being the longest part;
// priming and counting items run through fetch, prime or count, and emit.
// One item is in work at a time; the next is taken once the result is
// loaded into the output register, which may still wait to be taken.
// Synchronous active-low reset restores the register defaults and clears
// the prescale counter, previous temperature, primed flag and fan level.
module pd_fan_level_regulator_core
    import pdfan_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port
    input  logic                      i_cfg_we,
    input  logic [CfgIdxW-1:0]        i_cfg_index,
    input  logic [CfgDatW-1:0]        i_cfg_data,
    // Input channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [TempW-1:0]   i_temperature,
    // Output channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [LevelW-1:0]         o_fan_level,
    output logic                      o_updated,
    output logic                      o_saturated
);

    // Configuration registers.
    logic signed [TempW-1:0]  r_nominal;
    logic signed [GainW-1:0]  r_gain_p;
    logic signed [GainW-1:0]  r_gain_d;
    logic [CfgDatW-1:0]       r_period;
    logic [CfgDatW-1:0]       r_reg_every;
    logic [LevelW-1:0]        r_max_level;

    // Regulator state.
    logic [CfgDatW-1:0]       r_prescale;
    logic signed [TempW-1:0]  r_prev;
    logic                     r_primed;
    logic [LevelW-1:0]        r_level;

    // Sequencer and datapath registers.
    logic [PcW-1:0]           r_pc;
    logic [PcW-1:0]           n_pc;
    logic signed [TempW-1:0]  r_cur;
    logic signed [ProdW-1:0]  r_p;
    logic signed [ProdW-1:0]  r_d;
    logic signed [AccW-1:0]   r_acc;
    logic                     r_neg;
    logic [QuoW-1:0]          r_quo;
    logic [CfgDatW-1:0]       r_rem;
    logic [CntW-1:0]          r_cnt;
    logic                     r_upd;
    logic                     r_sat;

    // Output register.
    logic                     r_out_valid;
    logic [LevelW-1:0]        r_out_level;
    logic                     r_out_upd;
    logic                     r_out_sat;

    t_ctrl                    ctrl;
    logic                     in_take;
    logic                     out_free;
    logic [CfgDatW-1:0]       period_eff;
    logic signed [DiffW-1:0]  diff_p;
    logic signed [DiffW-1:0]  diff_d;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [MulPW-1:0]  mul_prod;
    logic [AccW-1:0]          biased;
    logic [CfgDatW:0]         rem_sh;
    logic                     rem_ge;
    logic                     quo_big;
    logic signed [LevelW+2:0] level_sum;
    logic [LevelW-1:0]        level_new;
    logic                     sat_new;

    // Control word of the current step and the handshakes.
    assign ctrl        = f_ucode(r_pc);
    assign o_in_ready  = (ctrl.jmp == J_FETCH);
    assign in_take     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_fan_level = r_out_level;
    assign o_updated   = r_out_upd;
    assign o_saturated = r_out_sat;

    // A zero sample period divides as one.
    assign period_eff = (r_period == '0) ? {{(CfgDatW-1){1'b0}}, 1'b1} : r_period;

    // Temperature differences, one bit wider than a sample.
    assign diff_p = DiffW'(r_nominal) - DiffW'(r_cur);
    assign diff_d = DiffW'(r_cur) - DiffW'(r_prev);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.op)
            OP_MUL_P: begin
                mul_a = MulAW'(r_gain_p);
                mul_b = diff_p;
            end
            OP_MUL_D: begin
                mul_a = MulAW'(r_gain_d);
                mul_b = diff_d;
            end
            OP_MUL_S: begin
                mul_a = MulAW'(r_p);
                mul_b = signed'({1'b0, period_eff});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_prod = mul_a * mul_b;

    // Rounding bias of half the divisor times 4096, before the shift.
    assign biased = r_acc + (AccW'(period_eff) << (FracW - 1));

    // One restoring divider iteration.
    assign rem_sh = {r_rem, r_quo[QuoW-1]};
    assign rem_ge = (rem_sh >= {1'b0, period_eff});

    // New fan level from the signed quotient, clamped to its range.
    assign quo_big   = |r_quo[QuoW-1:LevelW+1];
    assign level_sum = r_neg
        ? ((LevelW+3)'(r_level) - (LevelW+3)'(r_quo[LevelW:0]))
        : ((LevelW+3)'(r_level) + (LevelW+3)'(r_quo[LevelW:0]));
    always_comb begin
        level_new = level_sum[LevelW-1:0];
        sat_new   = 1'b0;
        priority if (quo_big && r_neg) begin
            level_new = '0;
            sat_new   = 1'b1;
        end else if (quo_big) begin
            level_new = r_max_level;
            sat_new   = 1'b1;
        end else if (level_sum < 0) begin
            level_new = '0;
            sat_new   = 1'b1;
        end else if (level_sum > signed'((LevelW+3)'(r_max_level))) begin
            level_new = r_max_level;
            sat_new   = 1'b1;
        end else begin
            level_new = level_sum[LevelW-1:0];
            sat_new   = 1'b0;
        end
    end

    // Next step of the program.
    always_comb begin
        n_pc = r_pc + 1'b1;
        unique case (ctrl.jmp)
            J_NEXT:   n_pc = r_pc + 1'b1;
            J_ALWAYS: n_pc = ctrl.target;
            J_FETCH: begin
                priority if (!in_take) begin
                    n_pc = r_pc;
                end else if (!r_primed) begin
                    n_pc = APrime;
                end else if (r_prescale != '0) begin
                    n_pc = ACount;
                end else begin
                    n_pc = ctrl.target;
                end
            end
            J_LOOP:     n_pc = (r_cnt != '0) ? r_pc : (r_pc + 1'b1);
            J_WAIT_OUT: n_pc = out_free ? ctrl.target : r_pc;
            default:    n_pc = AFetch;
        endcase
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= AFetch;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal   <= 16'sd960;
            r_gain_p    <= 16'sd256;
            r_gain_d    <= '0;
            r_period    <= 16'd1;
            r_reg_every <= 16'd1;
            r_max_level <= 8'd7;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgNominal:  r_nominal   <= signed'(i_cfg_data);
                CfgGainP:    r_gain_p    <= signed'(i_cfg_data);
                CfgGainD:    r_gain_d    <= signed'(i_cfg_data);
                CfgPeriod:   r_period    <= i_cfg_data;
                CfgRegEvery: r_reg_every <= i_cfg_data;
                CfgMaxLevel: r_max_level <= i_cfg_data[LevelW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Regulator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale  <= '0;
            r_prev      <= '0;
            r_primed    <= 1'b0;
            r_level     <= '0;
        end else begin
            unique case (ctrl.op)
                OP_PRIME: begin
                    r_prev   <= r_cur;
                    r_primed <= 1'b1;
                end
                OP_COUNT: r_prescale <= r_prescale - 1'b1;
                OP_APPLY: begin
                    r_level    <= level_new;
                    r_prev     <= r_cur;
                    r_prescale <= r_reg_every - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Output valid flag: set when a result is loaded, cleared once it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.op == OP_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Datapath registers, loaded as the control word says.
    always_ff @(posedge i_clk) begin
        unique case (ctrl.op)
            OP_LOAD: begin
                if (in_take) begin
                    r_cur <= i_temperature;
                    r_upd <= 1'b0;
                    r_sat <= 1'b0;
                end
            end
            OP_MUL_P: r_p   <= mul_prod[ProdW-1:0];
            OP_MUL_D: r_d   <= mul_prod[ProdW-1:0];
            OP_MUL_S: r_acc <= mul_prod[AccW-1:0];
            OP_ADD_D: r_acc <= r_acc + AccW'(r_d);
            OP_ABS: begin
                r_neg <= r_acc[AccW-1];
                r_acc <= r_acc[AccW-1] ? -r_acc : r_acc;
            end
            OP_BIAS: begin
                r_quo <= biased[AccW-1:FracW];
                r_rem <= '0;
                r_cnt <= CntW'(QuoW - 1);
            end
            OP_DIV: begin
                r_quo <= {r_quo[QuoW-2:0], rem_ge};
                r_rem <= rem_ge ? CfgDatW'(rem_sh - {1'b0, period_eff})
                                : rem_sh[CfgDatW-1:0];
                r_cnt <= r_cnt - 1'b1;
            end
            OP_APPLY: begin
                r_upd <= 1'b1;
                r_sat <= sat_new;
            end
            OP_EMIT: begin
                if (out_free) begin
                    r_out_level <= r_level;
                    r_out_upd   <= r_upd;
                    r_out_sat   <= r_sat;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
